### rtl/interval_attribute_range_assign_assert.svh
// assertion macros for the interval attribute range assign block
// used by the top level; expects clk_i and rst_ni in the including module
`ifndef INTERVAL_ATTRIBUTE_RANGE_ASSIGN_ASSERT_SVH
`define INTERVAL_ATTRIBUTE_RANGE_ASSIGN_ASSERT_SVH
`ifndef SYNTH
`define IARA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iara assertion failed");
`define IARA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("iara assertion failed");
`else
`define IARA_ASSERT(lbl, prop)
`define IARA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/iara_pkg.sv
// shared types, constants and helper functions for the interval table block
// no dependencies
package iara_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_COLUMN    = 16383;
  localparam int COL_W         = 14;
  localparam int VAL_W         = 16;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 2);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_SET_WIDTH   = 2'd0,
    CMD_SET_HIDDEN  = 2'd1,
    CMD_SET_OUTLINE = 2'd2,
    CMD_READ        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SPAN  = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WALK, S_TAIL_GAP, S_FLUSH, S_PAD, S_COMMIT, S_DONE
  } state_e;

  typedef struct packed {
    col_t       first;
    col_t       last;
    logic [15:0] width;
    logic       width_set;
    logic       hidden;
    logic [7:0] outline;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t rec;
  } emit_t;

  typedef struct packed {
    logic a_shift;
    logic b_shift;
    logic commit;
  } cell_ctl_t;

  function automatic entry_t apply_attr(entry_t e, cmd_e c, logic [VAL_W-1:0] v);
    entry_t r;
    r = e;
    case (c)
      CMD_SET_WIDTH: begin
        r.width     = v;
        r.width_set = 1'b1;
      end
      CMD_SET_HIDDEN: r.hidden = |v;
      default: r.outline = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic same_attrs(entry_t a, entry_t b);
    return (a.width == b.width) && (a.width_set == b.width_set) &&
           (a.hidden == b.hidden) && (a.outline == b.outline);
  endfunction

endpackage

### rtl/iara_cell.sv
// one position of the interval chain: live entry and scratch entry
// depends on iara_pkg
module iara_cell (
  input  logic               clk_i,
  input  iara_pkg::cell_ctl_t ctl_i,
  input  iara_pkg::entry_t   a_in_i,
  input  iara_pkg::entry_t   b_in_i,
  output iara_pkg::entry_t   a_o,
  output iara_pkg::entry_t   b_o
);
  import iara_pkg::*;

  entry_t a_q, b_q;

  // live entry: rotates toward the head, or takes the scratch copy
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      a_q <= b_q;
    end else if (ctl_i.a_shift) begin
      a_q <= a_in_i;
    end
  end

  // scratch entry: shifts toward the head on each push or pad
  always_ff @(posedge clk_i) begin
    if (ctl_i.b_shift) begin
      b_q <= b_in_i;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
endmodule

### rtl/iara_merge.sv
// pending-record stage that coalesces emitted intervals and counts pushes
// depends on iara_pkg
module iara_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              flush_i,
  input  iara_pkg::emit_t   emit_i,
  output iara_pkg::emit_t   push_o,
  output iara_pkg::cnt_t    cnt_o
);
  import iara_pkg::*;

  entry_t p_q, p_d;
  logic   pv_q, pv_d;
  cnt_t   cnt_q, cnt_d;
  logic   joinable;

  // adjacent and equal attributes extend the pending record
  assign joinable = pv_q &&
                    (({1'b0, p_q.last} + (COL_W+1)'(1)) == {1'b0, emit_i.rec.first}) &&
                    same_attrs(p_q, emit_i.rec);

  always_comb begin
    p_d          = p_q;
    pv_d         = pv_q;
    push_o.valid = 1'b0;
    push_o.rec   = p_q;
    if (emit_i.valid) begin
      if (joinable) begin
        p_d.last = emit_i.rec.last;
      end else begin
        push_o.valid = pv_q;
        p_d          = emit_i.rec;
        pv_d         = 1'b1;
      end
    end
    if (flush_i) begin
      push_o.valid = pv_q;
      pv_d         = 1'b0;
    end
    cnt_d = cnt_q;
    if (push_o.valid && (cnt_q <= cnt_t'(TABLE_ENTRIES))) begin
      cnt_d = cnt_q + cnt_t'(1);
    end
    if (clear_i) begin
      pv_d  = 1'b0;
      cnt_d = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      pv_q  <= pv_d;
      cnt_q <= cnt_d;
    end
  end

  // pending payload
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign cnt_o = cnt_q;
endmodule

### rtl/interval_attribute_range_assign.sv
// Column interval table with range assignment of width, hidden or outline level.
// Input channel in_valid_i/in_ready_o carries one command per transaction;
// output channel out_valid_o/out_ready_i returns exactly one result per command.
// The table lives in a chain of TABLE_ENTRIES cells; a second chain holds the
// rewritten table while an assign walks the old one.
// A bad span or bad index answers without walking the chain. A read rotates the
// chain once. An assign rotates the chain once, emitting up to four parts per
// valid entry (left part, gap, updated part, right part), then pads the scratch
// chain to TABLE_ENTRIES shifts and copies it back.
// One command is in work at a time; a new one is accepted once the previous
// result has been moved into the output register.
// Reset clears the entry count to zero and empties the output register; table
// contents are not cleared, only positions below the count are ever read.
// A stalled receiver holds the result; the block finishes the next command and
// then waits until the output register is free.
module interval_attribute_range_assign (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [13:0]           range_first_i,
  input  logic [13:0]           range_last_i,
  input  logic [15:0]           new_value_i,
  input  logic [5:0]            entry_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [6:0]            entry_count_o,
  output logic [13:0]           out_first_o,
  output logic [13:0]           out_last_o,
  output logic [15:0]           out_width_o,
  output logic                  out_has_width_o,
  output logic                  out_hidden_o,
  output logic [7:0]            out_outline_o
);
  import iara_pkg::*;
  `include "interval_attribute_range_assign_assert.svh"

  state_e state_q, state_d;
  cmd_e   cmd_q;
  col_t   first_q, last_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] idx_q;
  cnt_t   rot_q, rot_d;
  cnt_t   bsh_q, bsh_d;
  cnt_t   count_q, count_d;
  logic [1:0] sub_q, sub_d;
  logic [COL_W:0] cursor_q, cursor_d;
  status_e res_status_q, res_status_d;
  entry_t  res_rec_q, res_rec_d;
  logic    out_valid_q, out_load;
  status_e out_status_q;
  cnt_t    out_count_q;
  entry_t  out_rec_q;

  entry_t    a_out [TABLE_ENTRIES];
  entry_t    b_out [TABLE_ENTRIES];
  cell_ctl_t ctl;
  emit_t     emit, push;
  logic      merge_clear, merge_flush, overflow, pad;
  cnt_t      merge_cnt;
  logic      accept;

  // chain of table cells; head is cell 0, rotation feeds the head into the tail
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t a_in, b_in;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign a_in = a_out[0];
      assign b_in = push.rec;
    end else begin : g_body
      assign a_in = a_out[i+1];
      assign b_in = b_out[i+1];
    end
    iara_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .a_in_i (a_in),
      .b_in_i (b_in),
      .a_o    (a_out[i]),
      .b_o    (b_out[i])
    );
  end

  // coalescing stage in front of the scratch chain
  iara_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (merge_clear),
    .flush_i (merge_flush),
    .emit_i  (emit),
    .push_o  (push),
    .cnt_o   (merge_cnt)
  );

  assign overflow = merge_cnt > cnt_t'(TABLE_ENTRIES);
  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // walk helpers on the head entry
  entry_t head, gap_rec, mid_rec, left_rec, right_rec;
  logic   below, above, cur_le_last;
  col_t   lo, hi;
  entry_t blank;

  always_comb begin
    blank       = '0;
    head        = a_out[0];
    below       = head.last < first_q;
    above       = head.first > last_q;
    lo          = (head.first > first_q) ? head.first : first_q;
    hi          = (head.last < last_q) ? head.last : last_q;
    cur_le_last = cursor_q <= {1'b0, last_q};
    gap_rec       = apply_attr(blank, cmd_q, val_q);
    gap_rec.first = cursor_q[COL_W-1:0];
    gap_rec.last  = last_q;
    left_rec      = head;
    left_rec.last = first_q - col_t'(1);
    mid_rec       = apply_attr(head, cmd_q, val_q);
    mid_rec.first = lo;
    mid_rec.last  = hi;
    right_rec       = head;
    right_rec.first = last_q + col_t'(1);
  end

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    rot_d        = rot_q;
    sub_d        = sub_q;
    cursor_d     = cursor_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    ctl          = '0;
    emit         = '0;
    emit.rec     = gap_rec;
    merge_clear  = 1'b0;
    merge_flush  = 1'b0;
    pad          = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rot_d        = '0;
          sub_d        = '0;
          cursor_d     = {1'b0, range_first_i};
          res_rec_d    = '0;
          res_status_d = ST_OK;
          merge_clear  = 1'b1;
          if (cmd_e'(command_i) == CMD_READ) begin
            if (cnt_t'(entry_index_i) >= count_q) begin
              res_status_d = ST_BAD_INDEX;
              state_d      = S_DONE;
            end else begin
              state_d = S_READ;
            end
          end else if ((range_first_i > range_last_i) ||
                       ({1'b0, range_last_i} > (COL_W+1)'(MAX_COLUMN))) begin
            res_status_d = ST_BAD_SPAN;
            state_d      = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_READ: begin
        if (rot_q == cnt_t'(TABLE_ENTRIES)) begin
          state_d = S_DONE;
        end else begin
          if (rot_q == cnt_t'(idx_q)) res_rec_d = head;
          ctl.a_shift = 1'b1;
          rot_d       = rot_q + cnt_t'(1);
        end
      end
      S_WALK: begin
        if (rot_q == cnt_t'(TABLE_ENTRIES)) begin
          state_d = S_TAIL_GAP;
        end else if (rot_q >= count_q) begin
          ctl.a_shift = 1'b1;
          rot_d       = rot_q + cnt_t'(1);
        end else if (below) begin
          emit.valid  = 1'b1;
          emit.rec    = head;
          ctl.a_shift = 1'b1;
          rot_d       = rot_q + cnt_t'(1);
        end else if (above) begin
          if (sub_q == 2'd0) begin
            if (cur_le_last) begin
              emit.valid = 1'b1;
              cursor_d   = {1'b0, last_q} + (COL_W+1)'(1);
            end
            sub_d = 2'd1;
          end else begin
            emit.valid  = 1'b1;
            emit.rec    = head;
            ctl.a_shift = 1'b1;
            rot_d       = rot_q + cnt_t'(1);
            sub_d       = 2'd0;
          end
        end else begin
          // overlap: left part, gap, updated part, right part
          sub_d = sub_q + 2'd1;
          case (sub_q)
            2'd0: begin
              emit.valid = head.first < first_q;
              emit.rec   = left_rec;
            end
            2'd1: begin
              emit.valid    = cursor_q < {1'b0, lo};
              emit.rec      = gap_rec;
              emit.rec.last = lo - col_t'(1);
            end
            2'd2: begin
              emit.valid = 1'b1;
              emit.rec   = mid_rec;
              cursor_d   = {1'b0, hi} + (COL_W+1)'(1);
            end
            default: begin
              emit.valid  = head.last > last_q;
              emit.rec    = right_rec;
              ctl.a_shift = 1'b1;
              rot_d       = rot_q + cnt_t'(1);
            end
          endcase
        end
      end
      S_TAIL_GAP: begin
        emit.valid = cur_le_last;
        state_d    = S_FLUSH;
      end
      S_FLUSH: begin
        merge_flush = 1'b1;
        state_d     = S_PAD;
      end
      S_PAD: begin
        if (bsh_q == cnt_t'(TABLE_ENTRIES)) begin
          state_d = S_COMMIT;
        end else begin
          pad = 1'b1;
        end
      end
      S_COMMIT: begin
        if (overflow) begin
          res_status_d = ST_FULL;
        end else begin
          ctl.commit = 1'b1;
          count_d    = merge_cnt;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    ctl.b_shift = (push.valid || pad) && (bsh_q < cnt_t'(TABLE_ENTRIES));
  end

  assign bsh_d = merge_clear ? '0 : (ctl.b_shift ? bsh_q + cnt_t'(1) : bsh_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rot_q       <= '0;
      bsh_q       <= '0;
      sub_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rot_q   <= rot_d;
      bsh_q   <= bsh_d;
      sub_q   <= sub_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      first_q <= range_first_i;
      last_q  <= range_last_i;
      val_q   <= new_value_i;
      idx_q   <= entry_index_i;
    end
    cursor_q     <= cursor_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
      out_rec_q    <= res_rec_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = 7'(out_count_q);
  assign out_first_o     = out_rec_q.first;
  assign out_last_o      = out_rec_q.last;
  assign out_width_o     = out_rec_q.width;
  assign out_has_width_o = out_rec_q.width_set;
  assign out_hidden_o    = out_rec_q.hidden;
  assign out_outline_o   = out_rec_q.outline;

  // checks
  `IARA_ASSERT_ALWAYS(a_count_bound, count_q <= cnt_t'(TABLE_ENTRIES))
  `IARA_ASSERT_ALWAYS(a_rot_bound, rot_q <= cnt_t'(TABLE_ENTRIES))
  `IARA_ASSERT(a_pad_full, (state_q == S_COMMIT) |-> (bsh_q == cnt_t'(TABLE_ENTRIES)))
  `IARA_ASSERT(a_commit_count, (state_q == S_COMMIT) && !overflow |=> (count_q == $past(merge_cnt)))
endmodule

### tb/interval_attribute_range_assign_tb.sv
// testbench for the column interval table with range assignment
// depends on iara_pkg and the interval_attribute_range_assign top level
module interval_attribute_range_assign_tb;
  import iara_pkg::*;

  typedef struct {
    logic [13:0] first;
    logic [13:0] last;
    logic [15:0] width;
    logic        width_set;
    logic        hidden;
    logic [7:0]  outline;
  } span_t;

  typedef struct {
    status_e     status;
    logic [6:0]  count;
    span_t       rd;
  } outcome_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0]  command_i;
  logic [13:0] range_first_i, range_last_i;
  logic [15:0] new_value_i;
  logic [5:0]  entry_index_i;
  logic [1:0]  status_o;
  logic [6:0]  entry_count_o;
  logic [13:0] out_first_o, out_last_o;
  logic [15:0] out_width_o;
  logic        out_has_width_o, out_hidden_o;
  logic [7:0]  out_outline_o;

  span_t    col_table[TABLE_ENTRIES];
  int       col_count;
  outcome_t expected_q[$];
  int       fail_cnt = 0;
  int       idle_cycles = 0;

  interval_attribute_range_assign u_dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic span_t with_attr(span_t e, cmd_e c, logic [15:0] v);
    span_t r;
    r = e;
    case (c)
      CMD_SET_WIDTH: begin
        r.width = v;
        r.width_set = 1'b1;
      end
      CMD_SET_HIDDEN: r.hidden = (v != 0);
      default: r.outline = v[7:0];
    endcase
    return r;
  endfunction

  // append to the rebuilt table, merging with an equal neighbor
  function automatic void push_span(ref span_t q[$], input span_t e);
    span_t p;
    if (q.size() > 0) begin
      p = q[$];
      if (int'(p.last) + 1 == int'(e.first) && p.width == e.width &&
          p.width_set == e.width_set && p.hidden == e.hidden &&
          p.outline == e.outline) begin
        q[$].last = e.last;
        return;
      end
    end
    q.insert(q.size(), e);
  endfunction

  function automatic span_t gap_span(int a, int b, cmd_e c, logic [15:0] v);
    span_t g;
    g = '{default: '0};
    g.first = 14'(a);
    g.last = 14'(b);
    return with_attr(g, c, v);
  endfunction

  // predicted result of one command, updating the table copy
  function automatic outcome_t predict_command(cmd_e c, int f, int l, logic [15:0] v,
                                               int idx);
    outcome_t o;
    span_t q[$];
    span_t e, m;
    int cursor, lo, hi;
    o = '{status: ST_OK, count: '0, rd: '{default: '0}};
    if (c == CMD_READ) begin
      if (idx >= col_count) o.status = ST_BAD_INDEX;
      else o.rd = col_table[idx];
    end else if (f > l || l > MAX_COLUMN) begin
      o.status = ST_BAD_SPAN;
    end else begin
      cursor = f;
      for (int i = 0; i < col_count; i++) begin
        e = col_table[i];
        if (e.last < f) push_span(q, e);
        else if (e.first > l) begin
          if (cursor <= l) begin
            push_span(q, gap_span(cursor, l, c, v));
            cursor = l + 1;
          end
          push_span(q, e);
        end else begin
          lo = (e.first > f) ? e.first : f;
          hi = (e.last < l) ? e.last : l;
          if (e.first < f) begin
            m = e;
            m.last = 14'(f - 1);
            push_span(q, m);
          end
          if (cursor < lo) push_span(q, gap_span(cursor, lo - 1, c, v));
          m = e;
          m.first = 14'(lo);
          m.last = 14'(hi);
          push_span(q, with_attr(m, c, v));
          cursor = hi + 1;
          if (e.last > l) begin
            m = e;
            m.first = 14'(l + 1);
            push_span(q, m);
          end
        end
      end
      if (cursor <= l) push_span(q, gap_span(cursor, l, c, v));
      if (q.size() > TABLE_ENTRIES) o.status = ST_FULL;
      else begin
        foreach (q[i]) col_table[i] = q[i];
        col_count = q.size();
      end
    end
    o.count = 7'(col_count);
    return o;
  endfunction

  // send one command transaction and log its expected result
  task automatic send_command(cmd_e c, int f, int l, logic [15:0] v, int idx);
    int gap;
    gap = $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= c;
    range_first_i <= 14'(f);
    range_last_i <= 14'(l);
    new_value_i <= v;
    entry_index_i <= 6'(idx);
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.insert(expected_q.size(), predict_command(c, f, l, v, idx));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic read_all();
    for (int i = 0; i <= col_count && i < 64; i++)
      send_command(CMD_READ, 0, 0, 16'h0, i);
  endtask

  // field extremes, every command, bad span and bad index
  task automatic test_directed();
    send_command(CMD_READ, 0, 0, 16'h0, 0);
    send_command(CMD_READ, 0, 0, 16'h0, 63);
    send_command(CMD_SET_WIDTH, 10, 5, 16'h1234, 0);
    send_command(CMD_SET_WIDTH, 16383, 16383, 16'hffff, 0);
    send_command(CMD_SET_WIDTH, 0, 16383, 16'h0000, 0);
    send_command(CMD_SET_HIDDEN, 100, 200, 16'h8000, 0);
    send_command(CMD_SET_OUTLINE, 150, 300, 16'hff07, 0);
    send_command(CMD_SET_HIDDEN, 100, 200, 16'h0000, 0);
    send_command(CMD_SET_OUTLINE, 150, 300, 16'h0000, 0);
    read_all();
    send_command(CMD_SET_WIDTH, 0, 16383, 16'h0000, 0);
    send_command(CMD_READ, 0, 0, 16'h0, 0);
  endtask

  // fill the table with alternating single columns to force table full
  task automatic test_table_full();
    for (int i = 0; i < 66; i++)
      send_command(CMD_SET_OUTLINE, 2 * i, 2 * i, 16'(i + 1), 0);
    send_command(CMD_SET_HIDDEN, 1, 1, 16'h1, 0);
    read_all();
    wait_drained();
    send_command(CMD_SET_WIDTH, 0, 16383, 16'h0100, 0);
    // outline zero everywhere folds the table back into one entry
    send_command(CMD_SET_OUTLINE, 0, 16383, 16'h0000, 0);
    send_command(CMD_SET_WIDTH, 0, 16383, 16'h0100, 0);
  endtask

  // random commands, mostly valid spans in a narrow region to build overlaps
  task automatic test_random(int n);
    int f, l, span_max;
    cmd_e c;
    for (int i = 0; i < n; i++) begin
      c = cmd_e'($urandom_range(0, 3));
      span_max = ($urandom_range(0, 9) == 0) ? 16383 : 400;
      f = $urandom_range(0, span_max);
      l = f + $urandom_range(0, 40);
      if ($urandom_range(0, 19) == 0) l = $urandom_range(0, 16383);
      if (l > 16383) l = 16383;
      if (i == n / 2) wait_drained();
      if ($urandom_range(0, 99) == 0) send_command(CMD_SET_WIDTH, 0, 16383, 16'h0, 0);
      send_command(c, f, l, 16'($urandom), c == CMD_READ ? $urandom_range(0, 63) : 0);
    end
  endtask

  // output ready with random stalls
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation");
        fail_cnt++;
      end else begin
        x = expected_q.pop_front();
        if (status_o !== x.status) begin
          $error("status exp %0d got %0d", x.status, status_o); fail_cnt++;
        end
        if (entry_count_o !== x.count) begin
          $error("entry_count exp %0d got %0d", x.count, entry_count_o); fail_cnt++;
        end
        if (out_first_o !== x.rd.first) begin
          $error("out_first exp %0d got %0d", x.rd.first, out_first_o); fail_cnt++;
        end
        if (out_last_o !== x.rd.last) begin
          $error("out_last exp %0d got %0d", x.rd.last, out_last_o); fail_cnt++;
        end
        if (out_width_o !== x.rd.width) begin
          $error("out_width exp %0h got %0h", x.rd.width, out_width_o); fail_cnt++;
        end
        if (out_has_width_o !== x.rd.width_set) begin
          $error("out_has_width exp %0b got %0b", x.rd.width_set, out_has_width_o);
          fail_cnt++;
        end
        if (out_hidden_o !== x.rd.hidden) begin
          $error("out_hidden exp %0b got %0b", x.rd.hidden, out_hidden_o); fail_cnt++;
        end
        if (out_outline_o !== x.rd.outline) begin
          $error("out_outline exp %0d got %0d", x.rd.outline, out_outline_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // main sequence
  initial begin
    col_count = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = '0;
    range_first_i = '0;
    range_last_i = '0;
    new_value_i = '0;
    entry_index_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_random(2000);
    wait_drained();
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
